/* sv/kstl_pkg.sv */
// ----------------------------------------------------------------------------
// kstl_pkg
// Shared types, constants and helpers for the keyed score table learner.
// ----------------------------------------------------------------------------
package kstl_pkg;

  localparam int TableEntriesDef = 16;
  localparam int MaxChannelsDef  = 8;
  localparam logic [15:0] ScoreOne = 16'd32768;

  // outcome scores, all products folded at elaboration
  localparam logic [15:0] ScoreFail     = 16'(32768 / 10);
  localparam logic [15:0] ScoreOkMid    = 16'((32768 * 9) / 10);
  localparam logic [15:0] ScoreOkSlow   = 16'((32768 * 8) / 10);
  localparam logic [15:0] ScoreFailMid  = 16'(((32768 / 10) * 9) / 10);
  localparam logic [15:0] ScoreFailSlow = 16'(((32768 / 10) * 8) / 10);

  localparam logic [0:0] CfgLearnOn  = 1'b0;
  localparam logic [0:0] CfgEntries  = 1'b1;

  typedef struct packed {
    logic [7:0]  key_type;
    logic [3:0]  used_prio;
    logic [31:0] chan_list;
    logic [7:0]  chan_count;
    logic        succeeded;
    logic [31:0] resp_seconds;
    logic [31:0] now_seconds;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic        was_hit;
    logic [3:0]  slot;
    logic [15:0] slot_score;
    logic [31:0] slot_freq;
    logic [15:0] mean_score;
    logic [31:0] learn_total;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input word, clear scan state
    logic scan;      // visit entry at scan index
    logic divide;    // run one step of the shared divider
    logic div_start; // load divider operands (sel picks which)
    logic [1:0] div_sel;
    logic commit;    // write chosen entry
    logic sum_scan;  // accumulate score at scan index
    logic finish;    // marks the result word latch; the datapath ignores it
    logic reject;
  } kstl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
    logic div_done;
  } kstl_stat_t;

  localparam logic [1:0] DivScore = 2'd0;
  localparam logic [1:0] DivResp  = 2'd1;
  localparam logic [1:0] DivMean  = 2'd2;

  // outcome score, picked from the constant table above
  function automatic logic [15:0] outcome_score(input logic ok, input logic [31:0] resp);
    logic [15:0] s;
    begin
      if (resp > 32'd300) s = ok ? ScoreOkSlow : ScoreFailSlow;
      else if (resp > 32'd60) s = ok ? ScoreOkMid : ScoreFailMid;
      else s = ok ? ScoreOne : ScoreFail;
      return s;
    end
  endfunction

endpackage

/* sv/kstl_ctrl.sv */
// ----------------------------------------------------------------------------
// kstl_ctrl
// Sequencer: search, pick, divide twice, commit, sum, divide, deliver; reject when learning is off.
// ----------------------------------------------------------------------------
module kstl_ctrl
  import kstl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_take,
  input  logic       learning_on,
  input  logic       out_free,
  input  kstl_stat_t stat,
  output kstl_cmd_t  cmd,
  output logic       busy,
  output logic       out_load
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_DSC   = 4'd2;
  localparam logic [3:0] S_DSCW  = 4'd3;
  localparam logic [3:0] S_DRS   = 4'd4;
  localparam logic [3:0] S_DRSW  = 4'd5;
  localparam logic [3:0] S_COMIT = 4'd6;
  localparam logic [3:0] S_SUM   = 4'd7;
  localparam logic [3:0] S_DMN   = 4'd8;
  localparam logic [3:0] S_DMNW  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;
  localparam logic [3:0] S_REJ   = 4'd11;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    cmd = '0;
    out_load = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: if (in_take) begin
        cmd.load = 1'b1;
        state_next = learning_on ? S_SCAN : S_REJ;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) state_next = S_DSC;
      end
      S_DSC: begin
        cmd.div_start = 1'b1; cmd.div_sel = DivScore; state_next = S_DSCW;
      end
      S_DSCW: begin
        cmd.divide = 1'b1;
        if (stat.div_done) state_next = S_DRS;
      end
      S_DRS: begin
        cmd.div_start = 1'b1; cmd.div_sel = DivResp; state_next = S_DRSW;
      end
      S_DRSW: begin
        cmd.divide = 1'b1;
        if (stat.div_done) state_next = S_COMIT;
      end
      S_COMIT: begin
        cmd.commit = 1'b1; state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum_scan = 1'b1;
        if (stat.scan_last) state_next = S_DMN;
      end
      S_DMN: begin
        cmd.div_start = 1'b1; cmd.div_sel = DivMean; state_next = S_DMNW;
      end
      S_DMNW: begin
        cmd.divide = 1'b1;
        if (stat.div_done) state_next = S_DONE;
      end
      S_DONE: if (out_free) begin
        cmd.finish = 1'b1; out_load = 1'b1; state_next = S_IDLE;
      end
      S_REJ: if (out_free) begin
        cmd.finish = 1'b1; cmd.reject = 1'b1; out_load = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

/* sv/kstl_dp.sv */
// ----------------------------------------------------------------------------
// kstl_dp
// Entry table, scans, divide-by-ten unit, restoring divider and result
// assembly.
// ----------------------------------------------------------------------------
module kstl_dp
  import kstl_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDef,
  parameter int MAX_CHANNELS  = MaxChannelsDef
) (
  input  logic       clk,
  input  logic       rst,
  input  kstl_cmd_t  cmd,
  input  in_word_t   in_word,
  input  logic [4:0] entries_in_use,
  output kstl_stat_t stat,
  output out_word_t  res
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int NCW = $clog2(MAX_CHANNELS + 1);
  localparam int DW = 36;   // dividend width (7*old+3*new fits 36 bits)
  localparam int D10Steps = DW / 12;  // 12-bit digits per divide by ten
  localparam logic [31:0] Recip10 = 32'd52429;  // 2^19 / 10, rounded up

  logic [7:0]  ent_key   [TABLE_ENTRIES];
  logic [3:0]  ent_prio  [TABLE_ENTRIES];
  logic [15:0] ent_score [TABLE_ENTRIES];
  logic [31:0] ent_freq  [TABLE_ENTRIES];
  logic [31:0] ent_resp  [TABLE_ENTRIES];
  logic [31:0] ent_chans [TABLE_ENTRIES];
  logic [NCW-1:0] ent_chan_cnt [TABLE_ENTRIES];
  logic [31:0] ent_stamp [TABLE_ENTRIES];

  logic [CW-1:0] filled;
  logic [31:0]   learn_counter;
  in_word_t      w;
  logic [15:0]   s_new;
  logic [CW-1:0] limit;

  logic [CW-1:0] idx;       // scan index
  logic          hit;
  logic          hit_now;
  logic [IW-1:0] sel;       // chosen slot
  logic [31:0]   oldest;
  logic [15:0]   old_score;
  logic [31:0]   old_resp;
  logic [31:0]   old_freq;
  logic [15:0]   new_score;
  logic [CW-1:0] filled_after;
  logic [19:0]   sum;

  // divider
  logic [DW-1:0] dv_q, dv_r;
  logic [DW-1:0] dv_d;
  logic [5:0]    dv_n;
  logic          dv_ten;
  logic [DW:0]   dv_trial;
  logic [15:0]   mean;

  // one 12-bit digit of a divide by ten
  logic [15:0]   d10_v;
  logic [31:0]   d10_p;
  logic [11:0]   d10_q;
  logic [15:0]   d10_tq;
  logic [3:0]    d10_r;

  logic [CW-1:0] scan_end;
  logic [IW-1:0] idx_i;

  assign idx_i = idx[IW-1:0];

  always_comb begin
    if (entries_in_use == 5'd0) limit = CW'(1);
    else if ({27'd0, entries_in_use} > TABLE_ENTRIES) limit = CW'(TABLE_ENTRIES);
    else limit = CW'(entries_in_use);
  end

  // search covers filled entries; when missing and full, oldest scan covers limit; sum scan covers filled
  always_comb begin
    scan_end = (filled > limit) ? filled : limit;
    if (cmd.sum_scan) scan_end = filled_after;
  end

  assign stat.scan_last = (idx + CW'(1) >= scan_end) || (scan_end == '0);
  assign dv_trial = {dv_r[DW-1:0], dv_q[DW-1]} - {1'b0, dv_d};
  assign stat.div_done = (dv_n == 6'd0);

  assign hit_now = (idx < filled) && (ent_key[idx_i] == w.key_type);

  assign d10_v  = {dv_r[3:0], dv_q[DW-1 -: 12]};
  assign d10_p  = {16'd0, d10_v} * Recip10;
  assign d10_q  = d10_p[30:19];
  assign d10_tq = {4'd0, d10_q} * 16'd10;
  assign d10_r  = d10_v[3:0] - d10_tq[3:0];

  function automatic logic [31:0] chan_mask(input logic [NCW-1:0] n);
    logic [31:0] m;
    begin
      m = '0;
      for (int k = 0; k < 8; k++)
        if (k < int'(n)) m[k*4 +: 4] = 4'hF;
      return m;
    end
  endfunction

  logic [NCW-1:0] ncl;
  assign ncl = (w.chan_count > 8'(MAX_CHANNELS)) ? NCW'(MAX_CHANNELS) : NCW'(w.chan_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
      learn_counter <= '0;
      dv_n <= '0;
    end else begin
      if (cmd.load) begin
        w <= in_word;
        s_new <= outcome_score(in_word.succeeded, in_word.resp_seconds);
        idx <= '0;
        hit <= 1'b0;
        sel <= '0;
        oldest <= 32'hFFFF_FFFF;
        sum <= '0;
      end
      if (cmd.scan) begin
        idx <= idx + CW'(1);
        if (!hit && hit_now) begin
          hit <= 1'b1;
          sel <= idx_i;
        end else if (!hit && stat.scan_last && filled < limit) begin
          sel <= filled[IW-1:0];
        end else if (!hit && idx < limit && (idx == '0 || ent_stamp[idx_i] < oldest)) begin
          oldest <= ent_stamp[idx_i];
          sel <= idx_i;
        end
      end
      if (cmd.div_start) begin
        dv_r <= '0;
        dv_ten <= (cmd.div_sel != DivMean);
        if (cmd.div_sel == DivScore) begin
          old_score <= ent_score[sel];
          old_resp  <= ent_resp[sel];
          old_freq  <= ent_freq[sel];
          dv_q <= DW'(7 * {20'd0, ent_score[sel]} + 3 * {20'd0, s_new});
          dv_n <= 6'(D10Steps);
        end else if (cmd.div_sel == DivResp) begin
          dv_q <= DW'(7 * {4'd0, old_resp} + 3 * {4'd0, w.resp_seconds});
          dv_n <= 6'(D10Steps);
        end else begin
          dv_q <= DW'(sum);
          dv_d <= (filled == '0) ? DW'(1) : DW'(filled);
          dv_n <= 6'(DW);
        end
      end
      if (cmd.divide && dv_n != 6'd0) begin
        dv_n <= dv_n - 6'd1;
        if (dv_ten) begin
          dv_r <= DW'(d10_r);
          dv_q <= {dv_q[DW-13:0], d10_q};
        end else if (!dv_trial[DW]) begin
          dv_r <= dv_trial[DW-1:0];
          dv_q <= {dv_q[DW-2:0], 1'b1};
        end else begin
          dv_r <= {dv_r[DW-2:0], dv_q[DW-1]};
          dv_q <= {dv_q[DW-2:0], 1'b0};
        end
      end
      if (cmd.commit) begin
        idx <= '0;
        ent_stamp[sel] <= w.now_seconds;
        learn_counter <= learn_counter + 32'd1;
        if (hit) begin
          ent_score[sel] <= new_score;
          ent_resp[sel] <= dv_q[31:0];
          ent_freq[sel] <= old_freq + 32'd1;
          if (s_new > old_score) begin
            ent_prio[sel] <= w.used_prio;
            ent_chan_cnt[sel] <= ncl;
            ent_chans[sel] <= w.chan_list & chan_mask(ncl);
          end
        end else begin
          if (filled < limit) filled <= filled + CW'(1);
          ent_key[sel] <= w.key_type;
          ent_score[sel] <= s_new;
          ent_freq[sel] <= 32'd1;
          ent_resp[sel] <= w.resp_seconds;
          ent_prio[sel] <= w.used_prio;
          ent_chan_cnt[sel] <= ncl;
          ent_chans[sel] <= w.chan_list & chan_mask(ncl);
        end
      end
      if (cmd.sum_scan) begin
        idx <= idx + CW'(1);
        if (idx < filled) sum <= sum + {4'd0, ent_score[idx_i]};
      end
    end
  end

  // capture score quotient when resp division starts
  always_ff @(posedge clk) begin
    if (cmd.div_start && cmd.div_sel == DivResp) new_score <= dv_q[15:0];
  end

  assign filled_after = filled;
  assign mean = (filled == '0) ? 16'd0 : dv_q[15:0];

  always_comb begin
    res = '0;
    res.learn_total = learn_counter;
    if (cmd.reject) begin
      res.status = 1'b1;
    end else begin
      res.was_hit = hit;
      res.slot = 4'(sel);
      res.slot_score = ent_score[sel];
      res.slot_freq = ent_freq[sel];
      res.mean_score = mean;
    end
  end

  logic unused_ok;
  assign unused_ok = ^{ent_prio[0], ent_chans[0], ent_chan_cnt[0], cmd.finish,
                       d10_p[31], d10_p[18:0], d10_tq[15:4], dv_q[DW-1:32]};

endmodule

/* sv/keyed_score_table_learner_unit.sv */
// ----------------------------------------------------------------------------
// keyed_score_table_learner_unit
// Learns per-key delivery scores in a small fully associative table.
//
//  channel | direction | handshake    | word
//  in      | input     | valid/stall  | in_word_t
//  out     | output    | valid/stall  | out_word_t
//  cfg     | input     | valid/ready  | index + data
//
// One item passes through the key and oldest-entry scan, two 3-step
// divisions by ten, the sum scan and a 36-step division for the mean,
// then waits until the result register is free. A rejected item skips
// the table and returns a word with status set. The input stalls while an
// item is in process. Reset is synchronous and empties the table.
// The result register frees the controller once a word is taken.
// ----------------------------------------------------------------------------
module keyed_score_table_learner_unit
  import kstl_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDef,
  parameter int MAX_CHANNELS  = MaxChannelsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic       learning_on;
  logic [4:0] entries_in_use;
  kstl_cmd_t  cmd;
  kstl_stat_t stat;
  out_word_t  res;
  logic       busy, out_load, in_take;

  assign cfg_ready = 1'b1;
  assign in_stall = busy;
  assign in_take = in_valid && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_on <= 1'b1;
      entries_in_use <= 5'd16;
    end else if (cfg_valid) begin
      if (cfg_index == CfgLearnOn) learning_on <= cfg_data[0];
      else if (cfg_index == CfgEntries) entries_in_use <= cfg_data[4:0];
    end
  end

  kstl_ctrl u_ctrl (
    .clk, .rst, .in_take, .learning_on,
    .out_free(!out_valid || !out_stall),
    .stat, .cmd, .busy, .out_load
  );

  kstl_dp #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_CHANNELS(MAX_CHANNELS)) u_dp (
    .clk, .rst, .cmd, .in_word(in_data), .entries_in_use, .stat, .res
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data <= res;
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the keyed score table learner. Outcome words are
// driven under varying idle and stall pressure; a scoreboard keeps its own
// copy of the score table, predicts each result word and checks every
// returned word field by field in order. Both registers are swept between
// phases, including learning off, a one-entry table and a full table.
// ----------------------------------------------------------------------------
module tb_top;
  import kstl_pkg::*;

  class score_table_board;
    bit          learn_en;
    bit   [4:0]  entry_cap;
    int unsigned n_filled;
    bit   [31:0] steps;
    bit   [7:0]  t_key[16];
    bit   [15:0] t_score[16];
    bit   [31:0] t_freq[16];
    bit   [31:0] t_stamp[16];
    out_word_t   pending[$];
    int          errors;

    function new();
      learn_en = 1'b1;
      entry_cap = 5'd16;
      n_filled = 0;
      steps = 0;
      errors = 0;
    endfunction

    function bit [15:0] rate(bit ok, bit [31:0] resp);
      bit [31:0] s;
      s = ok ? 32'd32768 : 32'd3276;
      if (resp > 300) s = s * 8 / 10;
      else if (resp > 60) s = s * 9 / 10;
      return s[15:0];
    endfunction

    function void note_input(in_word_t w);
      out_word_t   r;
      int unsigned lim, idx, sum;
      bit          hit;
      bit   [15:0] s;
      r = '0;
      if (!learn_en) begin
        r.status = 1'b1;
        r.learn_total = steps;
        pending.push_back(r);
        return;
      end
      lim = (entry_cap < 1) ? 1 : (entry_cap > 16 ? 16 : entry_cap);
      s = rate(w.succeeded, w.resp_seconds);
      hit = 1'b0;
      idx = 0;
      for (int i = 0; i < n_filled; i++)
        if (!hit && t_key[i] == w.key_type) begin
          hit = 1'b1;
          idx = i;
        end
      if (hit) begin
        t_score[idx] = 16'((7 * t_score[idx] + 3 * s) / 10);
        t_freq[idx]++;
      end else begin
        if (n_filled < lim) begin
          idx = n_filled;
          n_filled++;
        end else begin
          idx = 0;
          for (int i = 1; i < lim; i++)
            if (t_stamp[i] < t_stamp[idx]) idx = i;
        end
        t_key[idx] = w.key_type;
        t_score[idx] = s;
        t_freq[idx] = 32'd1;
      end
      t_stamp[idx] = w.now_seconds;
      steps++;
      sum = 0;
      for (int i = 0; i < n_filled; i++) sum += t_score[i];
      r.was_hit = hit;
      r.slot = idx[3:0];
      r.slot_score = t_score[idx];
      r.slot_freq = t_freq[idx];
      r.mean_score = 16'(sum / n_filled);
      r.learn_total = steps;
      pending.push_back(r);
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      if (pending.size() == 0) begin
        $error("unexpected word %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++;
      end
      if (got.was_hit !== e.was_hit) begin
        $error("was_hit exp %0d got %0d", e.was_hit, got.was_hit); errors++;
      end
      if (got.slot !== e.slot) begin
        $error("slot exp %0d got %0d", e.slot, got.slot); errors++;
      end
      if (got.slot_score !== e.slot_score) begin
        $error("slot_score exp %0d got %0d", e.slot_score, got.slot_score); errors++;
      end
      if (got.slot_freq !== e.slot_freq) begin
        $error("slot_freq exp %0d got %0d", e.slot_freq, got.slot_freq); errors++;
      end
      if (got.mean_score !== e.mean_score) begin
        $error("mean_score exp %0d got %0d", e.mean_score, got.mean_score); errors++;
      end
      if (got.learn_total !== e.learn_total) begin
        $error("learn_total exp %0d got %0d", e.learn_total, got.learn_total); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 0;
  out_word_t   out_data;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = CfgLearnOn;
  logic [31:0] cfg_data = '0;

  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;
  bit   [31:0] clock_s = 1000;
  score_table_board board = new();

  always #4 clk = ~clk;

  keyed_score_table_learner_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) board.check_result(out_data);
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  // valid stays up after a word is taken; the next call or caller drops it
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(w);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    if (idx == CfgLearnOn) board.learn_en = val[0];
    else board.entry_cap = val[4:0];
  endtask

  function automatic in_word_t rand_word(int unsigned nkeys);
    in_word_t w;
    w.key_type = (nkeys == 0) ? 8'($urandom) : 8'($urandom_range(nkeys - 1));
    w.used_prio = 4'($urandom);
    w.chan_list = $urandom;
    w.chan_count = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(8));
    w.succeeded = 1'($urandom_range(1));
    case ($urandom_range(5))
      0: w.resp_seconds = $urandom;
      1: w.resp_seconds = $urandom_range(62, 59);
      2: w.resp_seconds = $urandom_range(302, 299);
      default: w.resp_seconds = $urandom_range(600);
    endcase
    if ($urandom_range(9) == 0) w.now_seconds = $urandom;
    else begin
      clock_s = clock_s + $urandom_range(3);
      w.now_seconds = clock_s;
    end
    return w;
  endfunction

  task automatic run_phase(int n, int unsigned nkeys);
    for (int i = 0; i < n; i++) send_word(rand_word(nkeys));
  endtask

  initial begin
    in_word_t w;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: field extremes, thresholds, failures, rejection
    w = '0;
    send_word(w);
    w = '1;
    send_word(w);
    w.key_type = 8'd0; w.succeeded = 1'b0; w.resp_seconds = 60;
    w.chan_count = 8'd8; w.now_seconds = 5;
    send_word(w);
    w.resp_seconds = 61; w.succeeded = 1'b1; w.now_seconds = 6;
    send_word(w);
    w.resp_seconds = 300; w.chan_count = 8'd3;
    send_word(w);
    w.resp_seconds = 301; w.key_type = 8'd7; w.chan_list = 0; w.used_prio = 4'd0;
    send_word(w);
    w.key_type = 8'hFF; w.succeeded = 1'b1; w.resp_seconds = 0;
    send_word(w);
    write_reg(CfgLearnOn, 0);
    send_word(w);
    send_word(rand_word(0));
    write_reg(CfgLearnOn, 1);
    write_reg(CfgEntries, 0);
    run_phase(12, 4);
    write_reg(CfgEntries, 31);
    run_phase(40, 24);

    write_reg(CfgEntries, 16);
    run_phase(350, 20);
    send_idle = 88;
    write_reg(CfgEntries, 4);
    run_phase(300, 8);
    send_idle = 0; recv_stall = 88;
    write_reg(CfgEntries, 1);
    run_phase(250, 3);
    write_reg(CfgEntries, 9);
    run_phase(200, 0);
    send_idle = 21; recv_stall = 21;
    write_reg(CfgEntries, 16);
    run_phase(300, 18);
    write_reg(CfgLearnOn, 0);
    run_phase(30, 18);
    write_reg(CfgLearnOn, 1);
    send_idle = 0; recv_stall = 0;
    run_phase(250, 12);

    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (board.errors == 0) $display("keyed_score_table_learner_unit regression: pass");
    else $display("keyed_score_table_learner_unit regression: fail");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("keyed_score_table_learner_unit regression: fail");
    $finish;
  end

endmodule
